// ===== rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared payload types, status codes and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int KEY_W           = 31;
    localparam int VALUE_W         = 32;

    // The home-slot unit folds the key in this many bits per clock cycle.
    localparam int HASH_BITS_PER_STEP = 8;
    localparam int HASH_STEPS         = 4;
    localparam int HASH_W             = HASH_BITS_PER_STEP * HASH_STEPS;

    typedef enum logic
    {
        KIND_INSERT = 1'b0,
        KIND_SEARCH = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed
    {
        kind_t                      kind;
        logic        [KEY_W-1:0]    key;
        logic signed [VALUE_W-1:0]  value;
    } req_t;

    typedef struct packed
    {
        status_t                    status;
        logic signed [VALUE_W-1:0]  found_value;
    } rsp_t;

    typedef struct packed
    {
        logic                       valid;
        logic        [KEY_W-1:0]    key;
        logic signed [VALUE_W-1:0]  value;
    } slot_t;

endpackage

`default_nettype wire

// ===== rtl/lpht_home_slot.sv =====
// ----------------------------------------------------------------------------
// Home slot unit
// Computes key modulo the slot count, one byte of the key per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_home_slot
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [KEY_W-1:0]                 key,
    output logic                                  done,
    output logic [$clog2(TABLE_SLOTS)-1:0]        rem
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int SW = $clog2(HASH_STEPS);
    localparam logic [IW:0]   SLOTS_C   = (IW+1)'(TABLE_SLOTS);
    localparam logic [SW-1:0] LAST_STEP = SW'(HASH_STEPS - 1);

    logic [HASH_W-1:0] shift_reg;
    logic [IW-1:0]     rem_reg;
    logic [SW-1:0]     step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [IW-1:0]     rem_next;

    always_comb
    begin
        logic [IW:0] t;
        logic [IW-1:0] r;
        r = rem_reg;
        for (int i = 0; i < HASH_BITS_PER_STEP; i++)
        begin
            t = {r, shift_reg[HASH_W-1-i]};
            if (t >= SLOTS_C)
            begin
                t = t - SLOTS_C;
            end
            r = t[IW-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= HASH_W'(key);
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << HASH_BITS_PER_STEP;
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/lpht_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_slot_ram
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0]   waddr,
    input  wire slot_t                            wdata,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0]   raddr,
    output slot_t                                 rdata
);

    slot_t mem [TABLE_SLOTS];
    slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing insert and search over a slot memory with linear probing.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory to mark every slot empty and
// takes no request during that time. A request then occupies the block while
// the home-slot unit folds the key into its home slot, the first slot read is
// issued, and the probe loop checks one slot per cycle, from 1 up to
// TABLE_SLOTS slots, through the single read port of the slot memory. The
// response sits in an output register, so the next request is taken while it
// waits.
`default_nettype none

module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire req_t  req,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    output rsp_t       rsp
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

    typedef enum logic [4:0]
    {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_HOLD  = 5'b10000
    } state_t;

    state_t        state_reg;
    logic [IW-1:0] clr_idx_reg;
    logic [IW-1:0] chk_idx_reg;
    logic [IW-1:0] issue_idx_reg;
    logic [IW-1:0] cnt_reg;
    req_t          req_reg;
    rsp_t          pend_reg;
    rsp_t          rsp_data_reg;
    logic          rsp_valid_reg;

    logic          hash_start;
    logic          hash_done;
    logic [IW-1:0] home_idx;
    logic          we;
    logic [IW-1:0] waddr;
    slot_t         wdata;
    logic [IW-1:0] raddr;
    slot_t         rdata;

    logic          slot_empty;
    logic          slot_match;
    logic          lap_end;
    logic          finish;
    rsp_t          result;
    logic          rsp_free;
    logic          rsp_load;
    logic [IW-1:0] home_next;
    logic [IW-1:0] issue_next;

    assign req_ready  = (state_reg == S_IDLE);
    assign hash_start = req_valid && req_ready;
    assign rsp_free   = !rsp_valid_reg || rsp_ready;
    assign rsp_load   = rsp_free && (((state_reg == S_PROBE) && finish) ||
                                     (state_reg == S_HOLD));

    assign home_next  = (home_idx == LAST) ? '0 : home_idx + 1'b1;
    assign issue_next = (issue_idx_reg == LAST) ? '0 : issue_idx_reg + 1'b1;
    assign raddr      = (state_reg == S_HASH) ? home_idx : issue_idx_reg;

    assign slot_empty = !rdata.valid;
    assign slot_match = rdata.valid && (rdata.key == req_reg.key);
    assign lap_end    = (cnt_reg == LAST);

    always_comb
    begin
        result.found_value = '0;
        if (req_reg.kind == KIND_INSERT)
        begin
            finish        = slot_empty || lap_end;
            result.status = slot_empty ? ST_INSERTED : ST_FULL;
        end
        else
        begin
            finish = slot_empty || slot_match || lap_end;
            if (slot_match)
            begin
                result.status      = ST_FOUND;
                result.found_value = rdata.value;
            end
            else
            begin
                result.status = ST_NOT_FOUND;
            end
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = chk_idx_reg;
        wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_idx_reg;
        end
        else if ((state_reg == S_PROBE) && (req_reg.kind == KIND_INSERT) && slot_empty)
        begin
            we          = 1'b1;
            wdata.valid = 1'b1;
            wdata.key   = req_reg.key;
            wdata.value = req_reg.value;
        end
    end

    lpht_home_slot #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_home_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (req.key),
        .done  (hash_done),
        .rem   (home_idx)
    );

    lpht_slot_ram #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (hash_start)
                    begin
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (finish)
                    begin
                        if (rsp_free)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_HOLD;
                        end
                    end
                end
                S_HOLD:
                begin
                    if (rsp_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (hash_start)
        begin
            req_reg <= req;
        end
        if ((state_reg == S_HASH) && hash_done)
        begin
            chk_idx_reg   <= home_idx;
            issue_idx_reg <= home_next;
            cnt_reg       <= '0;
        end
        else if (state_reg == S_PROBE)
        begin
            chk_idx_reg   <= issue_idx_reg;
            issue_idx_reg <= issue_next;
            cnt_reg       <= cnt_reg + 1'b1;
        end
        if ((state_reg == S_PROBE) && finish)
        begin
            if (rsp_free)
            begin
                rsp_data_reg <= result;
            end
            else
            begin
                pend_reg <= result;
            end
        end
        else if ((state_reg == S_HOLD) && rsp_free)
        begin
            rsp_data_reg <= pend_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;

    // A held result always has an occupied output register in front of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> rsp_valid_reg)
        else $error("hold state entered with a free output register");

    // The memory is written only by the clearing sweep or by an insert that lands on an empty slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ((state_reg == S_CLEAR) || (state_reg == S_PROBE)))
        else $error("slot memory written outside clearing or probing");

    // A probe write never overwrites an occupied slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (we && (state_reg == S_PROBE)) |-> (!rdata.valid && (req_reg.kind == KIND_INSERT)))
        else $error("probe wrote over an occupied slot");

    // Only a found result carries a nonzero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_data_reg.status != ST_FOUND))
            |-> (rsp_data_reg.found_value == '0))
        else $error("nonzero value on a result that is not found");

    // The home-slot unit finishes only while the controller waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == S_HASH))
        else $error("home slot finished outside the hash state");

endmodule

`default_nettype wire

// ===== tb/lpht_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear probe hash table checker
// Watches the request and response channels and keeps its own copy of the
// slot table. Every accepted request is applied to that copy in order, and the
// response it should produce is queued. Every accepted response is compared,
// field by field, with the oldest queued answer. The failure count and the
// number of answers still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module lpht_checker
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   outstanding
);

    logic                      tbl_used [TABLE_SLOTS];
    logic        [KEY_W-1:0]   tbl_key  [TABLE_SLOTS];
    logic signed [VALUE_W-1:0] tbl_val  [TABLE_SLOTS];
    rsp_t                      owed_answers[$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic rsp_t apply_request(input req_t r);
        rsp_t ans;
        int   idx;
        ans.status      = (r.kind == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
        ans.found_value = '0;
        idx = int'({1'b0, r.key} % TABLE_SLOTS);
        for (int n = 0; n < TABLE_SLOTS; n++)
        begin
            if (r.kind == KIND_INSERT)
            begin
                if (!tbl_used[idx])
                begin
                    tbl_used[idx] = 1'b1;
                    tbl_key[idx]  = r.key;
                    tbl_val[idx]  = r.value;
                    ans.status    = ST_INSERTED;
                    return ans;
                end
            end
            else
            begin
                if (!tbl_used[idx])
                begin
                    return ans;
                end
                if (tbl_key[idx] == r.key)
                begin
                    ans.status      = ST_FOUND;
                    ans.found_value = tbl_val[idx];
                    return ans;
                end
            end
            idx = (idx + 1 == TABLE_SLOTS) ? 0 : idx + 1;
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                tbl_used[i] = 1'b0;
            end
            owed_answers.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_answers.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected response, status %0d value %0d",
                                              rsp.status, rsp.found_value));
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp.status, want.status));
                    end
                    if (rsp.found_value !== want.found_value)
                    begin
                        report_mismatch($sformatf("found_value %0d, expected %0d",
                                                  rsp.found_value, want.found_value));
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                owed_answers.push_back(apply_request(req));
            end
            outstanding <= owed_answers.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives inserts and searches into the table: a directed opening that covers
// empty-slot misses, collisions, duplicate keys, wrap-around and field
// extremes, then random traffic that fills the table and keeps probing it
// once full. Both channels stall at random; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb
    import lpht_pkg::*;
();

    localparam int SLOTS        = TABLE_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT  = 5000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    int   fail_count;
    int   outstanding;
    bit   req_burst = 1'b0;
    bit   rsp_burst = 1'b0;

    logic [KEY_W-1:0] inserted_keys[$];

    linear_probe_hash_table_top #(.TABLE_SLOTS(SLOTS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lpht_checker #(.TABLE_SLOTS(SLOTS)) u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_request(input kind_t kind, input logic [KEY_W-1:0] key,
                                input logic signed [VALUE_W-1:0] value);
        int   gap;
        req_t item;
        gap = req_burst ? 0 : $urandom_range(0, 14);
        item.kind  = kind;
        item.key   = key;
        item.value = value;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        if (kind == KIND_INSERT)
        begin
            inserted_keys.push_back(key);
        end
    endtask

    task automatic wait_until_answered();
        int waited;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < DRAIN_LIMIT);
    endtask

    initial
    begin
        int stall;
        int taken;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 32 == 0)
            begin
                rsp_burst = ($urandom_range(0, 3) == 0);
            end
            stall = rsp_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(rsp_valid && rsp_ready));
            taken++;
        end
    end

    initial
    begin
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
        int                        roll;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_request(KIND_SEARCH, 31'd0, 32'sd0);
        send_request(KIND_INSERT, 31'd0, 32'sh7FFF_FFFF);
        send_request(KIND_INSERT, 31'd16, 32'sh8000_0000);
        send_request(KIND_INSERT, 31'd0, -32'sd1);
        send_request(KIND_SEARCH, 31'd0, 32'sd0);
        send_request(KIND_SEARCH, 31'd16, 32'sd0);
        send_request(KIND_SEARCH, 31'd32, 32'sd0);
        send_request(KIND_INSERT, 31'h7FFF_FFFF, 32'sd0);
        send_request(KIND_INSERT, 31'd31, 32'sh5555_5555);
        send_request(KIND_SEARCH, 31'd31, 32'sd0);
        send_request(KIND_SEARCH, 31'h7FFF_FFFF, 32'shAAAA_AAAA);
        send_request(KIND_INSERT, 31'h7FFF_FFF0, 32'shAAAA_AAAA);
        send_request(KIND_SEARCH, 31'h7FFF_FFF0, 32'sh5555_5555);
        send_request(KIND_SEARCH, 31'd47, 32'sd0);

        req_valid <= 1'b0;
        wait_until_answered();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 32 == 0)
            begin
                req_burst = ($urandom_range(0, 3) == 0);
            end
            if (i == RANDOM_ITEMS / 2)
            begin
                req_valid <= 1'b0;
                wait_until_answered();
            end
            value = VALUE_W'($urandom);
            roll  = $urandom_range(0, 99);
            if (roll < 35)
            begin
                case ($urandom_range(0, 2))
                    0: key = KEY_W'($urandom);
                    1: key = KEY_W'($urandom_range(0, 63));
                    default:
                        key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                endcase
                send_request(KIND_INSERT, key, value);
            end
            else
            begin
                if (roll < 80)
                begin
                    key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                end
                else if (roll < 92)
                begin
                    key = KEY_W'($urandom);
                end
                else
                begin
                    key = KEY_W'($urandom_range(0, 63));
                end
                send_request(KIND_SEARCH, key, value);
            end
        end

        req_valid <= 1'b0;
        wait_until_answered();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
